FILE: src/lrubc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lrubc_pkg;

	localparam int IdW = 31;
	localparam int WordW = 32;
	localparam int CountW = 32;
	localparam int MaxIdxW = 6;
	localparam int QueueDepth = 4;
	localparam int QueuePtrW = 2;

	typedef enum logic [1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_STORE = 2'd1,
		REQ_INVALIDATE = 2'd2,
		REQ_CLEAR = 2'd3
	} req_t;

	typedef enum logic {
		CMD_LOOKUP = 1'b0,
		CMD_WRITE = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic hit;
		logic [MaxIdxW-1:0] entry;
		logic [MaxIdxW-1:0] offset;
		logic [WordW-1:0] data;
		logic [CountW-1:0] lookups;
		logic [CountW-1:0] seqs;
		logic [CountW-1:0] rnds;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

	function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
		sat_inc = (v == {CountW{1'b1}}) ? v : v + CountW'(1);
	endfunction

endpackage
`default_nettype wire

FILE: src/lrubc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module lrubc_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire lrubc_pkg::cmd_t push_cmd,
	input wire logic pop,
	output lrubc_pkg::cmd_t head,
	output lrubc_pkg::queue_status_t status
);

	lrubc_pkg::cmd_t slot_q [lrubc_pkg::QueueDepth];
	logic [lrubc_pkg::QueuePtrW-1:0] wr_ptr_q;
	logic [lrubc_pkg::QueuePtrW-1:0] rd_ptr_q;
	logic [lrubc_pkg::QueuePtrW:0] count_q;

	assign head = slot_q[rd_ptr_q];
	assign status.empty = (count_q == '0);
	assign status.full = (count_q == (lrubc_pkg::QueuePtrW+1)'(lrubc_pkg::QueueDepth));

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/lrubc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module lrubc_front #(
	parameter int ENTRIES = 8,
	parameter int BLOCK_WORDS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] req_type,
	input wire logic [30:0] block_id,
	input wire logic [31:0] data_word,
	input wire logic word_last,
	input wire lrubc_pkg::queue_status_t q_status,
	output logic push,
	output lrubc_pkg::cmd_t push_cmd
);

	localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OW = $clog2(BLOCK_WORDS + 1);

	logic s1_valid_q;
	logic [1:0] req_s1;
	logic [30:0] id_s1;
	logic [31:0] word_s1;
	logic last_s1;

	logic [30:0] tag_q [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [31:0] stamp_q [ENTRIES];
	logic [31:0] next_stamp_q;
	logic [30:0] prev_id_q;
	logic prev_valid_q;
	logic store_active_q;
	logic [EW-1:0] store_entry_q;
	logic [OW-1:0] store_off_q;
	logic [31:0] lookups_q;
	logic [31:0] seqs_q;
	logic [31:0] rnds_q;

	logic work;
	logic match;
	logic [EW-1:0] match_idx;
	logic found_inv;
	logic [EW-1:0] victim;
	logic [31:0] best_stamp;
	logic [EW-1:0] wr_entry;
	logic [OW-1:0] wr_off;
	logic [30:0] diff;
	logic is_seq;

	assign in_stall = s1_valid_q;
	assign work = s1_valid_q && !q_status.full;

	always_comb begin
		match = 1'b0;
		match_idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!match && valid_q[i] && tag_q[i] == id_s1) begin
				match = 1'b1;
				match_idx = EW'(i);
			end
		end
	end

	always_comb begin
		found_inv = 1'b0;
		victim = '0;
		best_stamp = stamp_q[0];
		for (int i = 0; i < ENTRIES; i++) begin
			if (!found_inv && !valid_q[i]) begin
				found_inv = 1'b1;
				victim = EW'(i);
			end
		end
		if (!found_inv) begin
			for (int i = 1; i < ENTRIES; i++) begin
				if (stamp_q[i] < best_stamp) begin
					best_stamp = stamp_q[i];
					victim = EW'(i);
				end
			end
		end
	end

	assign diff = (prev_id_q > id_s1) ? prev_id_q - id_s1 : id_s1 - prev_id_q;
	assign is_seq = prev_valid_q && (diff <= 31'd1);
	assign wr_entry = store_active_q ? store_entry_q : victim;
	assign wr_off = store_active_q ? store_off_q : '0;

	always_comb begin
		push = 1'b0;
		push_cmd = '0;
		if (work) begin
			priority case (lrubc_pkg::req_t'(req_s1))
				lrubc_pkg::REQ_LOOKUP: begin
					push = 1'b1;
					push_cmd.kind = lrubc_pkg::CMD_LOOKUP;
					push_cmd.hit = match;
					push_cmd.entry = lrubc_pkg::MaxIdxW'(match_idx);
					push_cmd.lookups = lrubc_pkg::sat_inc(lookups_q);
					push_cmd.seqs = seqs_q;
					push_cmd.rnds = rnds_q;
				end
				lrubc_pkg::REQ_STORE: begin
					push = (wr_off < OW'(BLOCK_WORDS));
					push_cmd.kind = lrubc_pkg::CMD_WRITE;
					push_cmd.entry = lrubc_pkg::MaxIdxW'(wr_entry);
					push_cmd.offset = lrubc_pkg::MaxIdxW'(wr_off);
					push_cmd.data = word_s1;
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (!s1_valid_q) begin
			req_s1 <= req_type;
			id_s1 <= block_id;
			word_s1 <= data_word;
			last_s1 <= word_last;
		end
		if (work && req_s1 == lrubc_pkg::REQ_LOOKUP && match) begin
			stamp_q[match_idx] <= next_stamp_q;
		end
		if (work && req_s1 == lrubc_pkg::REQ_STORE && !store_active_q) begin
			tag_q[victim] <= id_s1;
			stamp_q[victim] <= next_stamp_q;
			prev_id_q <= id_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			valid_q <= '0;
			next_stamp_q <= '0;
			prev_valid_q <= 1'b0;
			store_active_q <= 1'b0;
			store_entry_q <= '0;
			store_off_q <= '0;
			lookups_q <= '0;
			seqs_q <= '0;
			rnds_q <= '0;
		end else begin
			if (!s1_valid_q) begin
				s1_valid_q <= in_valid;
			end else if (work) begin
				s1_valid_q <= 1'b0;
			end
			if (work) begin
				unique case (lrubc_pkg::req_t'(req_s1))
					lrubc_pkg::REQ_LOOKUP: begin
						lookups_q <= lrubc_pkg::sat_inc(lookups_q);
						if (match) begin
							next_stamp_q <= lrubc_pkg::sat_inc(next_stamp_q);
						end
					end
					lrubc_pkg::REQ_STORE: begin
						if (!store_active_q) begin
							valid_q[victim] <= 1'b1;
							next_stamp_q <= lrubc_pkg::sat_inc(next_stamp_q);
							prev_valid_q <= 1'b1;
							store_entry_q <= victim;
							if (is_seq) begin
								seqs_q <= lrubc_pkg::sat_inc(seqs_q);
							end else begin
								rnds_q <= lrubc_pkg::sat_inc(rnds_q);
							end
						end
						if (last_s1) begin
							store_active_q <= 1'b0;
							store_off_q <= '0;
						end else begin
							store_active_q <= 1'b1;
							store_off_q <= (wr_off < OW'(BLOCK_WORDS)) ?
								wr_off + 1'b1 : wr_off;
						end
					end
					lrubc_pkg::REQ_INVALIDATE: begin
						valid_q <= '0;
						next_stamp_q <= '0;
						prev_valid_q <= 1'b0;
						store_active_q <= 1'b0;
						store_off_q <= '0;
					end
					lrubc_pkg::REQ_CLEAR: begin
						lookups_q <= '0;
						seqs_q <= '0;
						rnds_q <= '0;
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/lrubc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module lrubc_back #(
	parameter int ENTRIES = 8,
	parameter int BLOCK_WORDS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire lrubc_pkg::cmd_t head,
	input wire lrubc_pkg::queue_status_t q_status,
	output logic pop,
	output logic out_valid,
	input wire logic out_stall,
	output logic hit,
	output logic [31:0] data_word_out,
	output logic run_last,
	output logic [31:0] request_count,
	output logic [31:0] sequential_count,
	output logic [31:0] random_count
);

	localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int WW = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
	localparam int Depth = ENTRIES * BLOCK_WORDS;
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SEND
	} state_t;

	state_t state_q;
	logic [31:0] mem [Depth];
	logic [31:0] rdata_q;
	lrubc_pkg::cmd_t cmd_q;
	logic [WW-1:0] word_q;
	logic out_free;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic do_write;

	assign out_free = !out_valid || !out_stall;
	assign wr_addr = AW'(EW'(head.entry) * BLOCK_WORDS) + AW'(WW'(head.offset));
	assign rd_addr = AW'(EW'(cmd_q.entry) * BLOCK_WORDS) + AW'(word_q);
	assign do_write = (state_q == ST_IDLE) && !q_status.empty &&
		head.kind == lrubc_pkg::CMD_WRITE;

	always_comb begin
		pop = 1'b0;
		if (state_q == ST_IDLE && !q_status.empty) begin
			pop = (head.kind == lrubc_pkg::CMD_WRITE) || head.hit || out_free;
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[wr_addr] <= head.data;
		end
		rdata_q <= mem[rd_addr];
		if (pop && head.kind == lrubc_pkg::CMD_LOOKUP && head.hit) begin
			cmd_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			word_q <= '0;
			out_valid <= 1'b0;
			hit <= 1'b0;
			data_word_out <= '0;
			run_last <= 1'b0;
			request_count <= '0;
			sequential_count <= '0;
			random_count <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop && head.kind == lrubc_pkg::CMD_LOOKUP && !head.hit) begin
						out_valid <= 1'b1;
						hit <= 1'b0;
						data_word_out <= '0;
						run_last <= 1'b1;
						request_count <= head.lookups;
						sequential_count <= head.seqs;
						random_count <= head.rnds;
					end else begin
						if (!out_stall) begin
							out_valid <= 1'b0;
						end
						if (pop && head.kind == lrubc_pkg::CMD_LOOKUP) begin
							word_q <= '0;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
					end
					state_q <= ST_SEND;
				end
				ST_SEND: begin
					if (out_free) begin
						out_valid <= 1'b1;
						hit <= 1'b1;
						data_word_out <= rdata_q;
						run_last <= (word_q == WW'(BLOCK_WORDS - 1));
						request_count <= cmd_q.lookups;
						sequential_count <= cmd_q.seqs;
						random_count <= cmd_q.rnds;
						if (word_q == WW'(BLOCK_WORDS - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							word_q <= word_q + 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				default: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
					end
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: src/lru_block_cache_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Fully associative block cache with least-recently-used replacement. The front end holds one
// request at a time and stalls its input while it does, matches tags, picks the victim, keeps
// stamps and statistics, and queues commands in a four-deep queue. The back end owns the block
// memory: it writes store words, a miss gives one beat, and a hit streams its words, each word
// through a read state for the registered memory read and a send state into the output register.
module lru_block_cache_core #(
	parameter int ENTRIES = 8,
	parameter int BLOCK_WORDS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] req_type,
	input wire logic [30:0] block_id,
	input wire logic [31:0] data_word,
	input wire logic word_last,
	output logic out_valid,
	input wire logic out_stall,
	output logic hit,
	output logic [31:0] data_word_out,
	output logic run_last,
	output logic [31:0] request_count,
	output logic [31:0] sequential_count,
	output logic [31:0] random_count
);

	logic push;
	logic pop;
	lrubc_pkg::cmd_t push_cmd;
	lrubc_pkg::cmd_t head;
	lrubc_pkg::queue_status_t q_status;

	lrubc_front #(.ENTRIES(ENTRIES), .BLOCK_WORDS(BLOCK_WORDS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .block_id(block_id),
		.data_word(data_word), .word_last(word_last),
		.q_status(q_status), .push(push), .push_cmd(push_cmd)
	);

	lrubc_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_cmd(push_cmd),
		.pop(pop), .head(head), .status(q_status)
	);

	lrubc_back #(.ENTRIES(ENTRIES), .BLOCK_WORDS(BLOCK_WORDS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.head(head), .q_status(q_status), .pop(pop),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .data_word_out(data_word_out), .run_last(run_last),
		.request_count(request_count), .sequential_count(sequential_count),
		.random_count(random_count)
	);

endmodule
`default_nettype wire

FILE: tb/lru_block_cache_core_tb.sv
`timescale 1ns / 1ps
module lru_block_cache_core_tb;

	localparam int NENT = 8;
	localparam int NWORDS = 16;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		lrubc_pkg::req_t kind;
		logic [30:0] id;
		logic [31:0] word;
		logic last;
	} req_item_t;

	typedef struct {
		logic hit;
		logic [31:0] word;
		logic last;
		logic [31:0] lookups;
		logic [31:0] seqs;
		logic [31:0] rnds;
	} beat_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] req_type;
	logic [30:0] block_id;
	logic [31:0] data_word;
	logic word_last;
	logic out_valid;
	logic out_stall;
	logic hit;
	logic [31:0] data_word_out;
	logic run_last;
	logic [31:0] request_count;
	logic [31:0] sequential_count;
	logic [31:0] random_count;

	lru_block_cache_core DUT (.*);

	req_item_t pending_reqs[$];
	beat_t expected_beats[$];
	int error_count;
	int idle_cycles;
	int beats_seen;
	int reqs_sent;
	int send_idle_pct;
	int recv_stall_pct;
	logic fed;

	logic [30:0] tag_m[NENT];
	logic valid_m[NENT];
	logic [31:0] stamp_m[NENT];
	logic [31:0] words_m[NENT][NWORDS];
	logic [31:0] stamp_next;
	logic [30:0] prev_id;
	logic prev_ok;
	logic storing;
	int store_ent;
	int store_off;
	logic [31:0] lookups_m;
	logic [31:0] seqs_m;
	logic [31:0] rnds_m;

	function automatic logic [31:0] bump(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	task automatic push_beat(input logic h, input logic [31:0] w, input logic l);
		beat_t b;
		b.hit = h;
		b.word = w;
		b.last = l;
		b.lookups = lookups_m;
		b.seqs = seqs_m;
		b.rnds = rnds_m;
		expected_beats.push_back(b);
	endtask

	task automatic predict_cache(input req_item_t r);
		int e;
		int found;
		logic [30:0] diff;
		found = -1;
		case (r.kind)
			lrubc_pkg::REQ_LOOKUP: begin
				lookups_m = bump(lookups_m);
				for (int i = 0; i < NENT; i++)
					if (found < 0 && valid_m[i] && tag_m[i] == r.id)
						found = i;
				if (found >= 0) begin
					stamp_m[found] = stamp_next;
					stamp_next = bump(stamp_next);
					for (int k = 0; k < NWORDS; k++)
						push_beat(1'b1, words_m[found][k], k == NWORDS - 1);
				end else begin
					push_beat(1'b0, 32'd0, 1'b1);
				end
			end
			lrubc_pkg::REQ_STORE: begin
				if (!storing) begin
					e = -1;
					for (int i = 0; i < NENT; i++)
						if (e < 0 && !valid_m[i])
							e = i;
					if (e < 0) begin
						e = 0;
						for (int i = 1; i < NENT; i++)
							if (stamp_m[i] < stamp_m[e])
								e = i;
					end
					store_ent = e;
					store_off = 0;
					storing = 1'b1;
					tag_m[e] = r.id;
					valid_m[e] = 1'b1;
					stamp_m[e] = stamp_next;
					stamp_next = bump(stamp_next);
					diff = (prev_id > r.id) ? prev_id - r.id : r.id - prev_id;
					if (prev_ok && diff <= 31'd1)
						seqs_m = bump(seqs_m);
					else
						rnds_m = bump(rnds_m);
					prev_id = r.id;
					prev_ok = 1'b1;
				end
				if (store_off < NWORDS) begin
					words_m[store_ent][store_off] = r.word;
					store_off++;
				end
				if (r.last) begin
					storing = 1'b0;
					store_off = 0;
				end
			end
			lrubc_pkg::REQ_INVALIDATE: begin
				for (int i = 0; i < NENT; i++)
					valid_m[i] = 1'b0;
				stamp_next = '0;
				prev_ok = 1'b0;
				storing = 1'b0;
				store_off = 0;
			end
			default: begin
				lookups_m = '0;
				seqs_m = '0;
				rnds_m = '0;
			end
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch at beat %0d: %s got %h want %h", beats_seen, what, got, want);
		error_count++;
	endtask

	function automatic req_item_t make_req(input lrubc_pkg::req_t k, input logic [30:0] id,
		input logic [31:0] w, input logic l);
		req_item_t r;
		r.kind = k;
		r.id = id;
		r.word = w;
		r.last = l;
		return r;
	endfunction

	// Full stores only, so every block word is written before any hit can read it.
	task automatic queue_store(input logic [30:0] id, input int len);
		for (int k = 0; k < len; k++)
			pending_reqs.push_back(make_req(lrubc_pkg::REQ_STORE,
				(k == 0) ? id : 31'($urandom), $urandom, k == len - 1));
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_type <= '0;
			block_id <= '0;
			data_word <= '0;
			word_last <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (fed && pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				req_item_t r;
				r = pending_reqs.pop_front();
				in_valid <= 1'b1;
				req_type <= r.kind;
				block_id <= r.id;
				data_word <= r.word;
				word_last <= r.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_cache(make_req(lrubc_pkg::req_t'(req_type), block_id, data_word,
					word_last));
				reqs_sent++;
			end
			if (out_valid && !out_stall) begin
				beat_t b;
				if (expected_beats.size() == 0) begin
					$display("unexpected beat %0d: word %h", beats_seen, data_word_out);
					error_count++;
				end else begin
					b = expected_beats.pop_front();
					if (hit !== b.hit) report_mismatch("hit", 32'(hit), 32'(b.hit));
					if (data_word_out !== b.word) report_mismatch("data_word_out",
						data_word_out, b.word);
					if (run_last !== b.last) report_mismatch("run_last", 32'(run_last),
						32'(b.last));
					if (request_count !== b.lookups) report_mismatch("request_count",
						request_count, b.lookups);
					if (sequential_count !== b.seqs) report_mismatch("sequential_count",
						sequential_count, b.seqs);
					if (random_count !== b.rnds) report_mismatch("random_count",
						random_count, b.rnds);
				end
				beats_seen++;
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("lru_block_cache_core_tb: errors");
				$finish;
			end
		end
	end

	task automatic drain;
		while (pending_reqs.size() > 0 || in_valid || expected_beats.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		logic [30:0] ids[$];
		int n;
		int op;
		logic [30:0] id;
		error_count = 0;
		idle_cycles = 0;
		beats_seen = 0;
		reqs_sent = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fed = 1'b0;
		for (int i = 0; i < NENT; i++) valid_m[i] = 1'b0;
		stamp_next = '0;
		prev_id = '0;
		prev_ok = 1'b0;
		storing = 1'b0;
		store_ent = 0;
		store_off = 0;
		lookups_m = '0;
		seqs_m = '0;
		rnds_m = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pending_reqs.push_back(make_req(lrubc_pkg::REQ_LOOKUP, 31'h7FFF_FFFF, '1, 1'b1));
		queue_store(31'h7FFF_FFFF, NWORDS);
		queue_store(31'h7FFF_FFFE, NWORDS + 3);
		pending_reqs.push_back(make_req(lrubc_pkg::REQ_LOOKUP, 31'h7FFF_FFFF, '0, 1'b0));
		pending_reqs.push_back(make_req(lrubc_pkg::REQ_LOOKUP, 31'd0, '1, 1'b1));
		pending_reqs.push_back(make_req(lrubc_pkg::REQ_LOOKUP, 31'd1, '0, 1'b0));
		pending_reqs.push_back(make_req(lrubc_pkg::REQ_CLEAR, '1, '1, 1'b1));
		pending_reqs.push_back(make_req(lrubc_pkg::REQ_LOOKUP, 31'h7FFF_FFFE, '0, 1'b0));
		pending_reqs.push_back(make_req(lrubc_pkg::REQ_INVALIDATE, '0, '0, 1'b0));
		pending_reqs.push_back(make_req(lrubc_pkg::REQ_LOOKUP, 31'd0, '0, 1'b0));
		fed = 1'b1;
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1 || phase == 3) ? 81 : 0;
			recv_stall_pct = (phase == 2) ? 81 : ((phase == 3) ? 9 : 0);
			if (phase == 3) send_idle_pct = 9;
			fed = 1'b0;
			n = 0;
			while (n < 16) begin
				op = $urandom_range(99);
				id = (ids.size() > 0 && $urandom_range(1)) ?
					ids[$urandom_range(ids.size() - 1)] + 31'($urandom_range(2)) - 31'd1 :
					31'($urandom);
				if (op < 30) begin
					queue_store(id, NWORDS);
					ids.push_back(id);
					n += NWORDS;
				end else if (op < 80) begin
					if (ids.size() > 0 && $urandom_range(3) != 0)
						id = ids[$urandom_range(ids.size() - 1)];
					pending_reqs.push_back(make_req(lrubc_pkg::REQ_LOOKUP, id, $urandom,
						1'($urandom)));
					n++;
				end else if (op < 86) begin
					// Lookup of another block placed in the middle of a store run.
					for (int k = 0; k < NWORDS; k++) begin
						pending_reqs.push_back(make_req(lrubc_pkg::REQ_STORE, id, $urandom,
							k == NWORDS - 1));
						if (k == 7 && ids.size() > 0 && ids[0] != id)
							pending_reqs.push_back(make_req(lrubc_pkg::REQ_LOOKUP,
								ids[0], $urandom, 1'b0));
					end
					ids.push_back(id);
					n += NWORDS + 1;
				end else if (op < 93) begin
					pending_reqs.push_back(make_req(lrubc_pkg::REQ_CLEAR, 31'($urandom),
						$urandom, 1'($urandom)));
					n++;
				end else begin
					pending_reqs.push_back(make_req(lrubc_pkg::REQ_INVALIDATE,
						31'($urandom), $urandom, 1'($urandom)));
					ids.delete();
					n++;
				end
			end
			fed = 1'b1;
			drain();
		end

		$display("covered %0d requests and %0d result beats over four traffic phases",
			reqs_sent, beats_seen);
		if (error_count == 0)
			$display("lru_block_cache_core_tb: clean");
		else
			$display("lru_block_cache_core_tb: errors");
		$finish;
	end
endmodule
